[hdl/fqd_pkg.sv]
// Shared types and constants for the FIFO queue with delete-by-value.
package fqd_pkg;

  localparam int DefCapacity = 16;
  localparam int ValW = 32;
  localparam int OutCntW = 5;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ITER = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SEARCH,
    S_SHIFT,
    S_ITER,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    latch_in;
    rd_sel_e rd_sel;
    logic    ptr_head;
    logic    ptr_inc;
    logic    wr_tail;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    head_inc;
    logic    res_load;
    logic    res_status;
    logic    res_valid;
    logic    res_last;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic val_zero;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic idx_last;
    logic res_last;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/fqd_ctrl.sv]
// Controller state machine that sequences each queue request.
module fqd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fqd_pkg::dp_stat_t stat_i,
  output fqd_pkg::dp_cmd_t  cmd_o
);
  import fqd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_HEAD;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_last = 1'b1;
        case (stat_i.op)
          OP_ENQ: begin
            cmd_o.res_load = 1'b1;
            if (stat_i.val_zero || stat_i.cnt_full) begin
              cmd_o.res_status = 1'b1;
            end else begin
              cmd_o.wr_tail = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
            state_d = S_EMIT;
          end
          OP_DEQ: begin
            if (stat_i.cnt_zero) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = 1'b1;
              state_d = S_EMIT;
            end else begin
              state_d = S_DEQ;
            end
          end
          OP_DEL: begin
            if (stat_i.val_zero || stat_i.cnt_zero) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = 1'b1;
              state_d = S_EMIT;
            end else begin
              cmd_o.ptr_head = 1'b1;
              state_d = S_SEARCH;
            end
          end
          default: begin
            if (stat_i.cnt_zero) begin
              cmd_o.res_load = 1'b1;
              state_d = S_EMIT;
            end else begin
              cmd_o.ptr_head = 1'b1;
              state_d = S_ITER;
            end
          end
        endcase
      end
      S_DEQ: begin
        cmd_o.res_load  = 1'b1;
        cmd_o.res_valid = 1'b1;
        cmd_o.res_last  = 1'b1;
        cmd_o.head_inc  = 1'b1;
        cmd_o.cnt_dec   = 1'b1;
        state_d = S_EMIT;
      end
      S_SEARCH: begin
        cmd_o.rd_sel = RD_NEXT;
        if (stat_i.match) begin
          state_d = S_SHIFT;
        end else if (stat_i.idx_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = 1'b1;
          cmd_o.res_last   = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_sel = RD_NEXT2;
        if (stat_i.idx_last) begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_last = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
        end
      end
      S_ITER: begin
        cmd_o.res_load  = 1'b1;
        cmd_o.res_valid = 1'b1;
        cmd_o.res_last  = stat_i.idx_last;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            cmd_o.rd_sel  = RD_NEXT;
            state_d = S_ITER;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/fqd_datapath.sv]
// Datapath: circular entry memory, pointers, count, pending result and output register.
module fqd_datapath #(
  parameter int CAPACITY = fqd_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fqd_pkg::dp_cmd_t              cmd_i,
  output fqd_pkg::dp_stat_t             stat_o,
  input  logic [1:0]                    operation_i,
  input  logic [fqd_pkg::ValW-1:0]      item_value_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic                          status_o,
  output logic [fqd_pkg::ValW-1:0]      out_value_o,
  output logic                          out_valid_o,
  output logic [fqd_pkg::OutCntW-1:0]   entry_count_o,
  output logic                          last_o
);
  import fqd_pkg::*;

  localparam int PtrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int SumW = CntW + 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CAPACITY - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CAPACITY);
  localparam logic [SumW-1:0] CapSum = SumW'(CAPACITY);

  logic [ValW-1:0] mem_q [CAPACITY];
  logic [ValW-1:0] rdata_q;
  logic [ValW-1:0] val_q;
  op_e             op_q;
  logic [PtrW-1:0] head_q, ptr_q, idx_q;
  logic [CntW-1:0] count_q;
  logic            res_status_q, res_valid_q, res_last_q;
  logic [ValW-1:0] res_value_q;
  logic            out_vld_q;
  logic            out_status_q, out_valid_q, out_last_q;
  logic [ValW-1:0] out_value_q;
  logic [CntW-1:0] out_count_q;

  logic [PtrW-1:0] ptr_next, ptr_next2, head_next, raddr, tail;
  logic [SumW-1:0] tail_sum;
  logic            out_free;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign ptr_next  = wrap_inc(ptr_q);
  assign ptr_next2 = wrap_inc(ptr_next);
  assign head_next = wrap_inc(head_q);
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail      = (tail_sum >= CapSum) ? PtrW'(tail_sum - CapSum) : PtrW'(tail_sum);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_NEXT:  raddr = ptr_next;
      RD_NEXT2: raddr = ptr_next2;
      default:  raddr = head_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tail) begin
      mem_q[tail] <= val_q;
    end else if (cmd_i.wr_shift) begin
      mem_q[ptr_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= op_e'(operation_i);
      val_q <= item_value_i;
    end
    if (cmd_i.ptr_head) begin
      ptr_q <= head_q;
      idx_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_next;
      idx_q <= idx_q + PtrW'(1);
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_valid_q  <= cmd_i.res_valid;
      res_last_q   <= cmd_i.res_last;
      res_value_q  <= cmd_i.res_valid ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_valid_q  <= res_valid_q;
      out_last_q   <= res_last_q;
      out_value_q  <= res_value_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.head_inc) begin
        head_q <= head_next;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_vld_q || res_ready_i;

  assign stat_o.op       = op_q;
  assign stat_o.val_zero = (val_q == '0);
  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.cnt_full = (count_q == FullCnt);
  assign stat_o.match    = (rdata_q == val_q);
  assign stat_o.idx_last = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign stat_o.res_last = res_last_q;
  assign stat_o.out_free = out_free;

  assign res_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign out_value_o   = out_value_q;
  assign out_valid_o   = out_valid_q;
  assign entry_count_o = OutCntW'(out_count_q);
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("Entry count exceeds capacity.");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastPtr)
    else $error("Head pointer out of range.");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("Output register overwritten while a result is pending.");
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> count_q == $past(count_q) + CntW'(1))
    else $error("Count did not advance on enqueue.");
`endif

endmodule

[hdl/fifo_queue_with_delete_unit.sv]
// Top level of the FIFO queue with delete-by-value.
// Requests are taken one at a time; the block holds up to CAPACITY nonzero values in a
// circular buffer with a registered read port. An enqueue goes through the idle, execute
// and emit states, and a dequeue also through its dequeue state, before its result
// reaches the output register. A delete reads one entry per cycle from the oldest until
// it finds a match, then moves each later entry down one slot per cycle. An iterate
// reads and emits one entry at a time over the single memory read port. A new request is
// taken once the previous one has placed its final result in the output register.
module fifo_queue_with_delete_unit #(
  parameter int CAPACITY = fqd_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [fqd_pkg::ValW-1:0]      item_value_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          status_o,
  output logic [fqd_pkg::ValW-1:0]      out_value_o,
  output logic                          out_valid_o,
  output logic [fqd_pkg::OutCntW-1:0]   entry_count_o,
  output logic                          last_o
);
  import fqd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fqd_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (operation_i),
    .item_value_i  (item_value_i),
    .res_ready_i   (res_ready_i),
    .res_valid_o   (res_valid_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .out_valid_o   (out_valid_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule
